[rtl/bmqf_pkg.sv]
// ----------------------------------------------------------------------------
// bmqf_pkg: shared definitions for the broadcast multi-queue FIFO
// Status codes, operation codes, fixed port widths and the per-cell control
// struct used between the top level and the queue cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bmqf_pkg;

  // Fixed field widths of the item streams.
  localparam int OP_W       = 1;
  localparam int QIDX_W     = 3;
  localparam int MSG_PORT_W = 64;
  localparam int STATUS_W   = 2;
  localparam int ACTIVE_W   = 4;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

  // Reset value of the active queue count.
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
  localparam logic [OP_W-1:0] OP_POP  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

  // Per-cell control for one cycle.
  typedef struct packed {
    logic clear;   // configuration write: empty every queue
    logic push;    // committed broadcast push
    logic pop;     // committed pop addressed to this cell
    logic active;  // this queue is in use
  } cell_ctrl_t;

endpackage : bmqf_pkg

`default_nettype wire

[rtl/broadcast_multi_queue_fifo_core.sv]
// ----------------------------------------------------------------------------
// broadcast_multi_queue_fifo_core: broadcast FIFO with several readers
// One shared message ring with a write position, plus a row of queue cells
// that each keep the fill count of one reader queue.
//
//   Channel  Direction  Handshake        Payload (lowest bit first)
//   in_      slave      tvalid/tready    operation, queue_index, message_in
//   out_     master     tvalid/tready    status, message_out
//   cfg_     write      we               active_queues
//
// One item is accepted per cycle while the read stage can move on; its result
// passes the registered read port of the message ring and the output register.
// Reset (rst_n low, synchronous) empties all queues and sets 8 active queues;
// ring contents are not cleared. A stalled output holds the result register
// and one item in the read stage; input is refused only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module broadcast_multi_queue_fifo_core #(
  parameter int MAX_QUEUES    = 8,
  parameter int QUEUE_DEPTH   = 16,
  parameter int MESSAGE_WIDTH = 64
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // operation [0], queue_index [3:1], message_in [67:4], zero [71:68]
  input  wire  [bmqf_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // status [1:0], message_out [65:2], zero [71:66]
  output logic [bmqf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  input  wire                                  cfg_we,
  input  wire  [bmqf_pkg::ACTIVE_W-1:0]        cfg_wdata
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;
  localparam int MSG_LO = bmqf_pkg::OP_W + bmqf_pkg::QIDX_W;
  localparam int OUT_PAD = bmqf_pkg::OUT_TDATA_W - bmqf_pkg::STATUS_W
                           - bmqf_pkg::MSG_PORT_W;

  // Input field unpacking.
  logic [bmqf_pkg::OP_W-1:0]       in_op;
  logic [bmqf_pkg::QIDX_W-1:0]     in_qi;
  logic [bmqf_pkg::MSG_PORT_W-1:0] in_msg;

  assign in_op  = in_tdata[0];
  assign in_qi  = in_tdata[MSG_LO-1:bmqf_pkg::OP_W];
  assign in_msg = in_tdata[MSG_LO+bmqf_pkg::MSG_PORT_W-1:MSG_LO];

  // State registers.
  logic [bmqf_pkg::ACTIVE_W-1:0]   active_r;
  logic [PTR_W-1:0]                wp_r;
  logic [PTR_W-1:0]                wp_nxt;
  logic [MESSAGE_WIDTH-1:0]        ring_mem [QUEUE_DEPTH];
  logic [MESSAGE_WIDTH-1:0]        rd_data_r;

  // Read stage and output register.
  logic                            st1_valid_r;
  logic [bmqf_pkg::STATUS_W-1:0]   st1_status_r;
  logic                            st1_hit_r;
  logic                            out_valid_r;
  logic [bmqf_pkg::STATUS_W-1:0]   out_status_r;
  logic [bmqf_pkg::MSG_PORT_W-1:0] out_msg_r;

  // Queue cell row.
  logic [CNT_W-1:0]                fill [MAX_QUEUES];
  logic [MAX_QUEUES:0]             full_chain;
  bmqf_pkg::cell_ctrl_t            cell_ctrl [MAX_QUEUES];

  logic                            in_acc;
  logic                            st1_adv;
  logic                            any_full;
  logic                            bad_idx;
  logic [CNT_W-1:0]                sel_fill;
  logic [bmqf_pkg::STATUS_W-1:0]   item_status;
  logic                            push_go;
  logic                            pop_go;
  logic [SUM_W-1:0]                slot_sum;
  logic [PTR_W-1:0]                slot;

  // Handshake: the read stage moves on when the output register frees up.
  assign st1_adv   = st1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !st1_valid_r || st1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign full_chain[0] = 1'b0;
  assign any_full      = full_chain[MAX_QUEUES];

  // Fill count of the addressed queue.
  always_comb begin
    sel_fill = '0;
    for (int q = 0; q < MAX_QUEUES; q++) begin
      if (int'(in_qi) == q) begin
        sel_fill = fill[q];
      end
    end
  end

  assign bad_idx = ({1'b0, in_qi} >= active_r) || (int'(in_qi) >= MAX_QUEUES);

  // Decide the outcome of the offered item.
  always_comb begin
    if (in_op == bmqf_pkg::OP_PUSH) begin
      item_status = any_full ? bmqf_pkg::ST_FULL : bmqf_pkg::ST_DONE;
    end else if (bad_idx) begin
      item_status = bmqf_pkg::ST_BADIDX;
    end else if (sel_fill == '0) begin
      item_status = bmqf_pkg::ST_EMPTY;
    end else begin
      item_status = bmqf_pkg::ST_DONE;
    end
  end

  assign push_go = in_acc && (in_op == bmqf_pkg::OP_PUSH) && !any_full;
  assign pop_go  = in_acc && (in_op == bmqf_pkg::OP_POP)
                   && (item_status == bmqf_pkg::ST_DONE);

  // Oldest slot of the addressed queue: write position minus fill, wrapped.
  always_comb begin
    slot_sum = SUM_W'(wp_r) + SUM_W'(QUEUE_DEPTH) - SUM_W'(sel_fill);
    if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
    end
    slot = slot_sum[PTR_W-1:0];
  end

  // Next write position with wrap at the ring depth.
  always_comb begin
    if (wp_r == PTR_W'(QUEUE_DEPTH - 1)) begin
      wp_nxt = '0;
    end else begin
      wp_nxt = wp_r + PTR_W'(1);
    end
  end

  // Queue cells, chained by the full-detect signal.
  for (genvar i = 0; i < MAX_QUEUES; i++) begin : g_cell
    always_comb begin
      cell_ctrl[i].clear  = cfg_we;
      cell_ctrl[i].push   = push_go;
      cell_ctrl[i].pop    = pop_go && (int'(in_qi) == i);
      cell_ctrl[i].active = (i < int'(active_r));
    end

    bmqf_queue_cell #(
      .DEPTH (QUEUE_DEPTH),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl[i]),
      .full_in  (full_chain[i]),
      .full_out (full_chain[i+1]),
      .fill     (fill[i])
    );
  end

  // Configuration register and write position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= bmqf_pkg::ACTIVE_RESET;
      wp_r     <= '0;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
      wp_r     <= '0;
    end else if (push_go) begin
      wp_r     <= wp_nxt;
    end
  end

  // Message ring: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (push_go) begin
      ring_mem[wp_r] <= in_msg[MESSAGE_WIDTH-1:0];
    end
    if (pop_go) begin
      rd_data_r <= ring_mem[slot];
    end
  end

  // Read stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_valid_r <= 1'b0;
    end else if (in_acc) begin
      st1_valid_r <= 1'b1;
    end else if (st1_adv) begin
      st1_valid_r <= 1'b0;
    end
  end

  // Read stage payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      st1_status_r <= item_status;
      st1_hit_r    <= pop_go;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload: message only on a completed pop.
  always_ff @(posedge clk) begin
    if (st1_adv) begin
      out_status_r <= st1_status_r;
      out_msg_r    <= st1_hit_r ? bmqf_pkg::MSG_PORT_W'(rd_data_r) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_msg_r, out_status_r};

`ifndef SYNTHESIS
  // An item never lands in the read stage while it still holds one.
  a_st1_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (st1_valid_r && !st1_adv) |-> !in_acc)
    else $error("read stage overwritten while stalled");

  // A refused push leaves the write position alone.
  a_refused_push_holds_wp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == bmqf_pkg::OP_PUSH) && any_full && !cfg_we) |=> $stable(wp_r))
    else $error("refused push moved the write position");

  // A completed push moves the write position.
  a_push_moves_wp: assert property (@(posedge clk) disable iff (!rst_n)
    (push_go && !cfg_we) |=> (wp_r != $past(wp_r)))
    else $error("completed push did not move the write position");

  // A message word is only shown with a done status.
  a_msg_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st1_adv && !st1_hit_r) |=> (out_msg_r == '0))
    else $error("message word present on a result that is not a pop");
`endif

endmodule : broadcast_multi_queue_fifo_core

`default_nettype wire

[rtl/bmqf_queue_cell.sv]
// ----------------------------------------------------------------------------
// bmqf_queue_cell: fill counter of one reader queue
// Holds the fill count of one queue and extends the full-detect chain that
// runs from the first cell to the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module bmqf_queue_cell #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire bmqf_pkg::cell_ctrl_t ctrl,
  input  wire                     full_in,
  output logic                    full_out,
  output logic [CNT_W-1:0]        fill
);

  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;

  // Count update: a push adds to every active queue, a pop takes from one.
  always_comb begin
    fill_nxt = fill_r;
    if (ctrl.clear) begin
      fill_nxt = '0;
    end else if (ctrl.push && ctrl.active) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Pass the full flag on to the next cell.
  assign full_out = full_in | (ctrl.active && (fill_r == CNT_W'(DEPTH)));
  assign fill     = fill_r;

endmodule : bmqf_queue_cell

`default_nettype wire
